@@ rtl/core/smpid_pkg.sv @@
// Shared widths, register indexes, limits and saturation helpers for the Smith predictor PID.
`timescale 1ns / 1ps
`default_nettype none

package smpid_pkg;

    // datapath word and delay line
    localparam int DW          = 32;
    localparam int DELAY_DEPTH = 1024;
    localparam int AW          = $clog2(DELAY_DEPTH);
    localparam int FILL_W      = AW + 1;

    // port fields
    localparam int IN_W       = 32;
    localparam int DRIVE_W    = 31;
    localparam int DELAY_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // shared multiplier: DW x MB_W signed, Q16.16 product keeps PW-FRAC bits
    localparam int MB_W = 33;
    localparam int PW   = DW + MB_W;
    localparam int FRAC = 16;
    localparam int QW   = PW - FRAC;
    localparam int SW   = QW + 2;
    localparam int TW   = ((QW > 63) ? QW : 63) + 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_POLE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_GAIN     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES  = 3'd7;

    // limits
    localparam logic signed [TW-1:0] TERM_LIMIT =
        {{(TW-62){1'b0}}, 1'b1, {61{1'b0}}};
    localparam logic signed [TW-1:0] DRIVE_LIMIT = TW'(655360000);
    localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT_OUT = 31'sd655360000;

    typedef struct packed {
        logic               start;
        logic [DELAY_W-1:0] delay;
    } hist_cmd_t;

    // clamp to a signed DW-bit word
    function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] x);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
        lo = ~hi;
        if (x > hi)
        begin
            sat_dw = hi[DW-1:0];
        end
        else if (x < lo)
        begin
            sat_dw = lo[DW-1:0];
        end
        else
        begin
            sat_dw = x[DW-1:0];
        end
    endfunction

    // clamp a PID term to +/- 2^61
    function automatic logic signed [TW-1:0] sat_term(input logic signed [QW-1:0] x);
        logic signed [TW-1:0] w;
        w = TW'(x);
        if (w > TERM_LIMIT)
        begin
            sat_term = TERM_LIMIT;
        end
        else if (w < -TERM_LIMIT)
        begin
            sat_term = -TERM_LIMIT;
        end
        else
        begin
            sat_term = w;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/smpid_sample_if.sv @@
// Sample request channel: setpoint and measurement.
`timescale 1ns / 1ps
`default_nettype none

interface smpid_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [smpid_pkg::IN_W-1:0]   target;
    logic signed [smpid_pkg::IN_W-1:0]   measured;

    modport source (output valid, output target, output measured, input ready);
    modport sink   (input valid, input target, input measured, output ready);
endinterface

`default_nettype wire

@@ rtl/core/smpid_result_if.sv @@
// Result request channel: clamped drive and clamp flag.
`timescale 1ns / 1ps
`default_nettype none

interface smpid_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [smpid_pkg::DRIVE_W-1:0]  drive;
    logic                                  clamped;

    modport source (output valid, output drive, output clamped, input ready);
    modport sink   (input valid, input drive, input clamped, output ready);
endinterface

`default_nettype wire

@@ rtl/core/smpid_history.sv @@
// Drive delay line: ring memory with write pointer, fill count and read forwarding.
`timescale 1ns / 1ps
`default_nettype none

module smpid_history
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire smpid_pkg::hist_cmd_t              cmd,
    input  wire logic signed [smpid_pkg::DW-1:0]   wdata,
    output logic signed [smpid_pkg::DW-1:0]        rdata
);

    logic signed [smpid_pkg::DW-1:0]     hist_mem [smpid_pkg::DELAY_DEPTH];
    logic [smpid_pkg::AW-1:0]            ptr_reg;
    logic [smpid_pkg::AW-1:0]            ptr_next;
    logic [smpid_pkg::FILL_W-1:0]        fill_reg;
    logic [smpid_pkg::FILL_W-1:0]        fill_next;
    logic                                fwd_reg;
    logic                                valid_reg;
    logic signed [smpid_pkg::DW-1:0]     hold_reg;
    logic signed [smpid_pkg::DW-1:0]     rd_q_reg;
    logic [smpid_pkg::AW-1:0]            rd_addr;
    logic                                rd_written;

    localparam logic [smpid_pkg::FILL_W-1:0] FILL_FULL =
        smpid_pkg::FILL_W'(smpid_pkg::DELAY_DEPTH);

    // delay taken modulo the depth; zero delay reads the entry being written
    assign rd_addr   = ptr_reg - smpid_pkg::AW'(cmd.delay);
    assign fill_next = (fill_reg == FILL_FULL) ? fill_reg : fill_reg + 1'b1;
    assign ptr_next  = ptr_reg + 1'b1;
    // entries below the fill count (this write included) hold real drives
    assign rd_written = ({1'b0, rd_addr} < fill_next);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            hist_mem[ptr_reg] <= wdata;
            rd_q_reg          <= hist_mem[rd_addr];
            hold_reg          <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            fill_reg  <= '0;
            fwd_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            ptr_reg   <= ptr_next;
            fill_reg  <= fill_next;
            fwd_reg   <= (rd_addr == ptr_reg);
            valid_reg <= rd_written;
        end
    end

    always_comb
    begin
        if (fwd_reg)
        begin
            rdata = hold_reg;
        end
        else if (valid_reg)
        begin
            rdata = rd_q_reg;
        end
        else
        begin
            rdata = '0;
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("history fill count beyond depth");

    a_ptr_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != FILL_FULL) |-> (ptr_reg == fill_reg[smpid_pkg::AW-1:0]))
        else $error("write pointer out of step with fill count");

    a_zero_delay_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start && (smpid_pkg::AW'(cmd.delay) == '0)) |=> fwd_reg)
        else $error("zero delay read not forwarded");
`endif

endmodule

`default_nettype wire

@@ rtl/core/smith_predictor_pid_top.sv @@
// Smith predictor with first-order process models feeding a clamped PID.
// A sample is taken only in the idle state, so the next one waits until the last is through;
// the single shared 32x33 multiplier runs the eleven products of a sample one after another.
// A finished result may wait in the output register while the next sample is taken.
// Reset: asynchronous, active low; the delay line reads as zero until written (fill count).
`timescale 1ns / 1ps
`default_nettype none

module smith_predictor_pid_top
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   wr_en,
    input  wire logic [smpid_pkg::CFG_IDX_W-1:0]        wr_index,
    input  wire logic [smpid_pkg::CFG_DATA_W-1:0]       wr_data,
    smpid_sample_if.sink                                sample,
    smpid_result_if.source                              result
);

    localparam int STATE_W = 4;
    localparam logic [STATE_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [STATE_W-1:0] ST_GAIN_NOW = 4'd1;
    localparam logic [STATE_W-1:0] ST_GAIN_OLD = 4'd2;
    localparam logic [STATE_W-1:0] ST_UND_POLE = 4'd3;
    localparam logic [STATE_W-1:0] ST_UND_IN   = 4'd4;
    localparam logic [STATE_W-1:0] ST_DEL_POLE = 4'd5;
    localparam logic [STATE_W-1:0] ST_DEL_IN   = 4'd6;
    localparam logic [STATE_W-1:0] ST_DEL_SUM  = 4'd7;
    localparam logic [STATE_W-1:0] ST_ERROR    = 4'd8;
    localparam logic [STATE_W-1:0] ST_ERR_DT   = 4'd9;
    localparam logic [STATE_W-1:0] ST_INTEG    = 4'd10;
    localparam logic [STATE_W-1:0] ST_DERIV    = 4'd11;
    localparam logic [STATE_W-1:0] ST_TERM_P   = 4'd12;
    localparam logic [STATE_W-1:0] ST_TERM_I   = 4'd13;
    localparam logic [STATE_W-1:0] ST_TERM_D   = 4'd14;
    localparam logic [STATE_W-1:0] ST_DONE     = 4'd15;

    localparam int DW = smpid_pkg::DW;
    localparam int SW = smpid_pkg::SW;
    localparam int QW = smpid_pkg::QW;
    localparam int TW = smpid_pkg::TW;

    // configuration
    logic signed [31:0]              prop_gain_reg;
    logic signed [31:0]              integ_gain_reg;
    logic signed [31:0]              deriv_gain_reg;
    logic [30:0]                     sample_period_reg;
    logic [30:0]                     inverse_period_reg;
    logic [15:0]                     model_pole_reg;
    logic signed [31:0]              model_gain_reg;
    logic [smpid_pkg::DELAY_W-1:0]   delay_samples_reg;

    // controller state
    logic signed [DW-1:0]            last_drive_reg;
    logic signed [DW-1:0]            undel_reg;
    logic signed [DW-1:0]            del_reg;
    logic signed [DW-1:0]            error_sum_reg;
    logic signed [DW-1:0]            prev_err_reg;

    // per-sample working registers
    logic [STATE_W-1:0]              state_reg;
    logic [STATE_W-1:0]              state_next;
    logic signed [DW-1:0]            target_reg;
    logic signed [DW-1:0]            measured_reg;
    logic signed [DW-1:0]            in_now_reg;
    logic signed [DW-1:0]            in_old_reg;
    logic signed [QW-1:0]            part_reg;
    logic signed [DW-1:0]            e_reg;
    logic signed [DW-1:0]            diff_reg;
    logic signed [DW-1:0]            es_new_reg;
    logic signed [DW-1:0]            deriv_reg;
    logic signed [TW-1:0]            term_acc_reg;
    logic signed [smpid_pkg::PW-1:0] prod_reg;

    // output register
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic signed [smpid_pkg::DRIVE_W-1:0] drive_reg;
    logic                            clamped_reg;

    logic signed [DW-1:0]            mul_a;
    logic signed [smpid_pkg::MB_W-1:0] mul_b;
    logic signed [QW-1:0]            q;
    logic signed [SW-1:0]            sat_arg;
    logic signed [DW-1:0]            sat_res;
    logic signed [TW-1:0]            term_q;
    logic signed [TW-1:0]            u_clamped;
    logic                            u_hit;
    logic [16:0]                     pole_comp;
    logic                            accept;
    logic                            out_free;
    logic signed [DW-1:0]            hist_rdata;
    smpid_pkg::hist_cmd_t            hist_cmd;

    assign accept    = sample.valid && sample.ready;
    assign out_free  = !out_valid_reg || result.ready;
    assign q         = prod_reg[smpid_pkg::PW-1:smpid_pkg::FRAC];
    assign term_q    = smpid_pkg::sat_term(q);
    assign pole_comp = 17'h10000 - {1'b0, model_pole_reg};

    assign sample.ready   = (state_reg == ST_IDLE);
    assign result.valid   = out_valid_reg;
    assign result.drive   = drive_reg;
    assign result.clamped = clamped_reg;

    assign hist_cmd.start = accept;
    assign hist_cmd.delay = delay_samples_reg;

    smpid_history u_history
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (hist_cmd),
        .wdata (last_drive_reg),
        .rdata (hist_rdata)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg      <= '0;
            integ_gain_reg     <= '0;
            deriv_gain_reg     <= '0;
            sample_period_reg  <= 31'd65536;
            inverse_period_reg <= 31'd65536;
            model_pole_reg     <= '0;
            model_gain_reg     <= 32'sd65536;
            delay_samples_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                smpid_pkg::REG_PROP_GAIN:      prop_gain_reg      <= wr_data;
                smpid_pkg::REG_INTEG_GAIN:     integ_gain_reg     <= wr_data;
                smpid_pkg::REG_DERIV_GAIN:     deriv_gain_reg     <= wr_data;
                smpid_pkg::REG_SAMPLE_PERIOD:  sample_period_reg  <= wr_data[30:0];
                smpid_pkg::REG_INVERSE_PERIOD: inverse_period_reg <= wr_data[30:0];
                smpid_pkg::REG_MODEL_POLE:     model_pole_reg     <= wr_data[15:0];
                smpid_pkg::REG_MODEL_GAIN:     model_gain_reg     <= wr_data;
                smpid_pkg::REG_DELAY_SAMPLES:
                    delay_samples_reg <= wr_data[smpid_pkg::DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // multiplier operand select: each step issues the product used by the next
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_GAIN_NOW:
            begin
                mul_a = last_drive_reg;
                mul_b = smpid_pkg::MB_W'(model_gain_reg);
            end
            ST_GAIN_OLD:
            begin
                mul_a = hist_rdata;
                mul_b = smpid_pkg::MB_W'(model_gain_reg);
            end
            ST_UND_POLE:
            begin
                mul_a = undel_reg;
                mul_b = smpid_pkg::MB_W'(model_pole_reg);
            end
            ST_UND_IN:
            begin
                mul_a = in_now_reg;
                mul_b = smpid_pkg::MB_W'(pole_comp);
            end
            ST_DEL_POLE:
            begin
                mul_a = del_reg;
                mul_b = smpid_pkg::MB_W'(model_pole_reg);
            end
            ST_DEL_IN:
            begin
                mul_a = in_old_reg;
                mul_b = smpid_pkg::MB_W'(pole_comp);
            end
            ST_ERR_DT:
            begin
                mul_a = e_reg;
                mul_b = smpid_pkg::MB_W'(sample_period_reg);
            end
            ST_INTEG:
            begin
                mul_a = diff_reg;
                mul_b = smpid_pkg::MB_W'(inverse_period_reg);
            end
            ST_DERIV:
            begin
                mul_a = e_reg;
                mul_b = smpid_pkg::MB_W'(prop_gain_reg);
            end
            ST_TERM_P:
            begin
                mul_a = es_new_reg;
                mul_b = smpid_pkg::MB_W'(integ_gain_reg);
            end
            ST_TERM_I:
            begin
                mul_a = deriv_reg;
                mul_b = smpid_pkg::MB_W'(deriv_gain_reg);
            end
            default: ;
        endcase
    end

    // one shared saturating adder
    always_comb
    begin
        case (state_reg)
            ST_DEL_POLE, ST_DEL_SUM:
                sat_arg = SW'(part_reg) + SW'(q);
            ST_ERROR:
                sat_arg = SW'(target_reg) - (SW'(measured_reg) + SW'(undel_reg)
                          - SW'(del_reg));
            ST_ERR_DT:
                sat_arg = SW'(e_reg) - SW'(prev_err_reg);
            ST_INTEG:
                sat_arg = SW'(error_sum_reg) + SW'(q);
            default:
                sat_arg = SW'(q);
        endcase
        sat_res = smpid_pkg::sat_dw(sat_arg);
    end

    // drive clamp
    always_comb
    begin
        u_hit     = 1'b0;
        u_clamped = term_acc_reg;
        if (term_acc_reg > smpid_pkg::DRIVE_LIMIT)
        begin
            u_clamped = smpid_pkg::DRIVE_LIMIT;
            u_hit     = 1'b1;
        end
        else if (term_acc_reg < -smpid_pkg::DRIVE_LIMIT)
        begin
            u_clamped = -smpid_pkg::DRIVE_LIMIT;
            u_hit     = 1'b1;
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
                state_next = accept ? ST_GAIN_NOW : ST_IDLE;
            ST_DONE:
                state_next = out_free ? ST_IDLE : ST_DONE;
            default:
                state_next = state_reg + 1'b1;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        if (state_reg == ST_DONE && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            last_drive_reg <= '0;
            undel_reg      <= '0;
            del_reg        <= '0;
            error_sum_reg  <= '0;
            prev_err_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            case (state_reg)
                ST_DEL_POLE: undel_reg <= sat_res;
                ST_DEL_SUM:  del_reg   <= sat_res;
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        last_drive_reg <= DW'(u_clamped);
                        prev_err_reg   <= e_reg;
                        // a clamp drops this sample's integral step
                        if (!u_hit)
                        begin
                            error_sum_reg <= es_new_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (accept)
        begin
            target_reg   <= sample.target;
            measured_reg <= sample.measured;
        end
        case (state_reg)
            ST_GAIN_OLD: in_now_reg   <= sat_res;
            ST_UND_POLE: in_old_reg   <= sat_res;
            ST_UND_IN:   part_reg     <= q;
            ST_DEL_IN:   part_reg     <= q;
            ST_ERROR:    e_reg        <= sat_res;
            ST_ERR_DT:   diff_reg     <= sat_res;
            ST_INTEG:    es_new_reg   <= sat_res;
            ST_DERIV:    deriv_reg    <= sat_res;
            ST_TERM_P:   term_acc_reg <= term_q;
            ST_TERM_I:   term_acc_reg <= term_acc_reg + term_q;
            ST_TERM_D:   term_acc_reg <= term_acc_reg + term_q;
            ST_DONE:
            begin
                if (out_free)
                begin
                    drive_reg   <= u_clamped[smpid_pkg::DRIVE_W-1:0];
                    clamped_reg <= u_hit;
                end
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !sample.ready)
        else $error("sample accepted while another is in work");

    a_drive_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.drive <= smpid_pkg::DRIVE_LIMIT_OUT
                          && result.drive >= -smpid_pkg::DRIVE_LIMIT_OUT))
        else $error("drive beyond limit");

    a_clamp_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.clamped) |-> (result.drive == smpid_pkg::DRIVE_LIMIT_OUT
                                             || result.drive == -smpid_pkg::DRIVE_LIMIT_OUT))
        else $error("clamp flag without drive at limit");
`endif

endmodule

`default_nettype wire
